// ===== design/twpp_pkg.sv =====
// ----------------------------------------------------------------------------
// twpp_pkg
// Shared types and constants for the TFT window and pixel write parser.
// ----------------------------------------------------------------------------
package twpp_pkg;

  // Preamble command bytes: column address set, page address set, memory write
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_PASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  // Preamble positions of interest
  localparam logic [3:0] POS_CASET  = 4'd0;
  localparam logic [3:0] POS_PASET  = 4'd5;
  localparam logic [3:0] POS_RAMWR  = 4'd10;
  localparam logic [3:0] POS_PIXELS = 4'd11;

  // Result status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_BAD_PREAMBLE  = 3'd1;
  localparam logic [2:0] ST_CMD_IN_PIXELS = 3'd2;
  localparam logic [2:0] ST_TOO_WIDE      = 3'd3;
  localparam logic [2:0] ST_TOO_TALL      = 3'd4;

  // Configuration register map
  localparam int         CFG_IDX_W      = 2;
  localparam int         CFG_DATA_W     = 11;
  localparam logic [1:0] CFG_MAX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAX_HEIGHT = 2'd1;
  localparam logic [10:0] CFG_LIMIT_RESET = 11'd1024;

  // One bus transfer
  typedef struct packed {
    logic       command;
    logic       is_data;
    logic [7:0] data_byte;
  } in_item_t;

  // Stored drawing window
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [10:0] width;
    logic [10:0] height;
  } window_t;

  // Preamble tracker result for one transfer
  typedef struct packed {
    logic [2:0] status;
    logic       win_set;
    logic       window_valid;
    window_t    window;
  } pre_res_t;

  // Pixel stream result for one transfer
  typedef struct packed {
    logic [2:0]  status;
    logic        write_valid;
    logic [19:0] pixel_index;
    logic [1:0]  channel;
    logic [7:0]  pixel_value;
    logic        flush;
    logic        frame_done;
  } pix_res_t;

endpackage

// ===== design/tft_window_and_pixel_write_parser.sv =====
// ----------------------------------------------------------------------------
// tft_window_and_pixel_write_parser
// Parses a TFT data/command byte stream into a drawing window and pixel writes.
// ----------------------------------------------------------------------------
// Takes one bus transfer per clock unless stalled and returns one result per
// transfer: the transfer is captured in an input register, decoded by the
// preamble tracker and pixel counters, and lands in the result register, which
// can hold a finished result while the next transfer is taken. The window is
// opened by 0x2A, four column bytes, 0x2B, four row bytes and 0x2C; later data
// bytes are R, G, B writes in row-major order. Limits are to be written via the cfg
// port (index 0 max width, 1 max height) while the block is idle (not enforced).
module tft_window_and_pixel_write_parser #(
  parameter int MAX_WIDTH_LIMIT  = 1024,
  parameter int MAX_HEIGHT_LIMIT = 1024,
  parameter int PIXELS_PER_FLUSH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic                             in_is_data,
  input  logic [7:0]                       in_data_byte,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_status,
  output logic                             out_write_valid,
  output logic [19:0]                      out_pixel_index,
  output logic [1:0]                       out_channel,
  output logic [7:0]                       out_pixel_value,
  output logic                             out_flush,
  output logic                             out_frame_done,
  output logic                             out_window_valid,
  output logic [15:0]                      out_window_left,
  output logic [15:0]                      out_window_top,
  output logic [10:0]                      out_window_width,
  output logic [10:0]                      out_window_height,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [twpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import twpp_pkg::*;

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_move, commit;
  logic [10:0] width_limit_r, height_limit_r;
  window_t    win_cur;
  logic       pixel_phase;
  pre_res_t   pre_res;
  pix_res_t   pix_res;

  logic        out_valid_r;
  pix_res_t    out_pix_r;
  logic [2:0]  out_status_r;
  logic        out_wvalid_r;
  window_t     out_win_r;

  // Pipeline flow: result register frees when empty or taken
  assign out_move = !out_valid_r || !out_stall;
  assign commit   = s1_valid_r && out_move;
  assign in_stall = s1_valid_r && !out_move;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= '{command: in_command, is_data: in_is_data, data_byte: in_data_byte};
    end
  end

  // Limit registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_limit_r  <= CFG_LIMIT_RESET;
      height_limit_r <= CFG_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_WIDTH:  width_limit_r  <= cfg_data;
        CFG_MAX_HEIGHT: height_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  twpp_preamble #(
    .MAX_WIDTH_LIMIT  (MAX_WIDTH_LIMIT),
    .MAX_HEIGHT_LIMIT (MAX_HEIGHT_LIMIT)
  ) u_preamble (
    .clk          (clk),
    .rst_n        (rst_n),
    .commit       (commit),
    .item         (s1_item_r),
    .width_limit  (width_limit_r),
    .height_limit (height_limit_r),
    .win_cur      (win_cur),
    .pixel_phase  (pixel_phase),
    .res          (pre_res)
  );

  twpp_pixel #(
    .MAX_WIDTH_LIMIT  (MAX_WIDTH_LIMIT),
    .MAX_HEIGHT_LIMIT (MAX_HEIGHT_LIMIT),
    .PIXELS_PER_FLUSH (PIXELS_PER_FLUSH)
  ) u_pixel (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (commit),
    .item        (s1_item_r),
    .pixel_phase (pixel_phase),
    .win_set     (pre_res.win_set),
    .win_cur     (win_cur),
    .res         (pix_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_pix_r    <= pix_res;
      out_status_r <= pixel_phase ? pix_res.status : pre_res.status;
      out_wvalid_r <= pre_res.window_valid;
      out_win_r    <= pre_res.window;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_write_valid   = out_pix_r.write_valid;
  assign out_pixel_index   = out_pix_r.pixel_index;
  assign out_channel       = out_pix_r.channel;
  assign out_pixel_value   = out_pix_r.pixel_value;
  assign out_flush         = out_pix_r.flush;
  assign out_frame_done    = out_pix_r.frame_done;
  assign out_window_valid  = out_wvalid_r;
  assign out_window_left   = out_win_r.left;
  assign out_window_top    = out_win_r.top;
  assign out_window_width  = out_win_r.width;
  assign out_window_height = out_win_r.height;

endmodule

// ===== design/twpp_preamble.sv =====
// ----------------------------------------------------------------------------
// twpp_preamble
// Tracks the 11-byte window preamble, holds the address bytes and the window.
// ----------------------------------------------------------------------------
module twpp_preamble #(
  parameter int MAX_WIDTH_LIMIT  = 1024,
  parameter int MAX_HEIGHT_LIMIT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               commit,
  input  twpp_pkg::in_item_t item,
  input  logic [10:0]        width_limit,
  input  logic [10:0]        height_limit,
  output twpp_pkg::window_t  win_cur,
  output logic               pixel_phase,
  output twpp_pkg::pre_res_t res
);
  import twpp_pkg::*;

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  addr_r [8];
  window_t     win_r, win_nxt;
  logic        addr_we;
  logic [2:0]  addr_idx;
  logic [7:0]  want;
  logic [15:0] x0, x1, y0, y1, xl, xh, yl, yh;
  logic [16:0] w_span, h_span, lim_w, lim_h;
  logic [2:0]  status;
  logic        win_set;

  // Window corners, big-endian pairs
  assign x0 = {addr_r[0], addr_r[1]};
  assign x1 = {addr_r[2], addr_r[3]};
  assign y0 = {addr_r[4], addr_r[5]};
  assign y1 = {addr_r[6], addr_r[7]};
  assign xl = (x0 < x1) ? x0 : x1;
  assign xh = (x0 < x1) ? x1 : x0;
  assign yl = (y0 < y1) ? y0 : y1;
  assign yh = (y0 < y1) ? y1 : y0;
  assign w_span = {1'b0, xh} - {1'b0, xl} + 17'd1;
  assign h_span = {1'b0, yh} - {1'b0, yl} + 17'd1;

  // Effective size limits: register clamped by the build-time cap
  assign lim_w = ({6'b0, width_limit} < 17'(MAX_WIDTH_LIMIT)) ?
                 {6'b0, width_limit} : 17'(MAX_WIDTH_LIMIT);
  assign lim_h = ({6'b0, height_limit} < 17'(MAX_HEIGHT_LIMIT)) ?
                 {6'b0, height_limit} : 17'(MAX_HEIGHT_LIMIT);

  assign want = (pos_r == POS_CASET) ? CMD_CASET :
                (pos_r == POS_PASET) ? CMD_PASET : CMD_RAMWR;
  assign addr_idx = (pos_r < POS_PASET) ? 3'(pos_r - 4'd1) : 3'(pos_r - 4'd2);

  // Preamble step
  always_comb begin
    pos_nxt = pos_r;
    win_nxt = win_r;
    status  = ST_OK;
    win_set = 1'b0;
    addr_we = 1'b0;
    if (item.command) begin
      pos_nxt = POS_CASET;
    end else if (pos_r < POS_PIXELS) begin
      if (pos_r == POS_CASET || pos_r == POS_PASET || pos_r == POS_RAMWR) begin
        if (item.is_data || item.data_byte != want) begin
          status = ST_BAD_PREAMBLE;
        end else if (pos_r == POS_RAMWR) begin
          if (w_span > lim_w) begin
            status = ST_TOO_WIDE;
          end else if (h_span > lim_h) begin
            status = ST_TOO_TALL;
          end else begin
            win_set        = 1'b1;
            win_nxt.left   = xl;
            win_nxt.top    = yl;
            win_nxt.width  = w_span[10:0];
            win_nxt.height = h_span[10:0];
          end
        end
      end else if (!item.is_data) begin
        status = ST_BAD_PREAMBLE;
      end else begin
        addr_we = 1'b1;
      end
      if (status == ST_OK) begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_CASET;
      win_r <= '{left: 16'd0, top: 16'd0, width: 11'd1, height: 11'd1};
    end else if (commit) begin
      pos_r <= pos_nxt;
      win_r <= win_nxt;
    end
  end

  // Address byte store, written once per preamble
  always_ff @(posedge clk) begin
    if (commit && addr_we) begin
      addr_r[addr_idx] <= item.data_byte;
    end
  end

  assign win_cur          = win_r;
  assign pixel_phase      = (pos_r == POS_PIXELS);
  assign res.status       = status;
  assign res.win_set      = win_set;
  assign res.window_valid = (pos_nxt == POS_PIXELS);
  assign res.window       = win_nxt;

endmodule

// ===== design/twpp_pixel.sv =====
// ----------------------------------------------------------------------------
// twpp_pixel
// Pixel stream counters: channel, pixel index, column/row and flush spacing.
// ----------------------------------------------------------------------------
module twpp_pixel #(
  parameter int MAX_WIDTH_LIMIT  = 1024,
  parameter int MAX_HEIGHT_LIMIT = 1024,
  parameter int PIXELS_PER_FLUSH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               commit,
  input  twpp_pkg::in_item_t item,
  input  logic               pixel_phase,
  input  logic               win_set,
  input  twpp_pkg::window_t  win_cur,
  output twpp_pkg::pix_res_t res
);
  import twpp_pkg::*;

  // Widest window the 11-bit limit registers can ever admit
  localparam int EFF_W  = (MAX_WIDTH_LIMIT < 2047) ? MAX_WIDTH_LIMIT : 2047;
  localparam int EFF_H  = (MAX_HEIGHT_LIMIT < 2047) ? MAX_HEIGHT_LIMIT : 2047;
  localparam int PIX_W  = $clog2(EFF_W * EFF_H + 1);
  localparam int FCNT_W = (PIXELS_PER_FLUSH > 1) ? $clog2(PIXELS_PER_FLUSH) : 1;
  localparam logic [FCNT_W-1:0] FCNT_LAST = FCNT_W'(PIXELS_PER_FLUSH - 1);

  logic [PIX_W-1:0]  pix_r, pix_nxt, pix_b;
  logic [1:0]        chan_r, chan_nxt, chan_b;
  logic [10:0]       col_r, col_nxt, col_b;
  logic [10:0]       row_r, row_nxt, row_b;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt, fcnt_b;
  logic              complete_r, complete_nxt;
  logic [31:0]       pidx32;
  logic              last_col, last_row;

  // Once the window is complete the next pixel starts over at zero
  assign pix_b  = complete_r ? '0 : pix_r;
  assign chan_b = complete_r ? 2'd0 : chan_r;
  assign col_b  = complete_r ? 11'd0 : col_r;
  assign row_b  = complete_r ? 11'd0 : row_r;
  assign fcnt_b = complete_r ? '0 : fcnt_r;
  assign pidx32 = 32'(pix_b);
  assign last_col = (col_b == win_cur.width - 11'd1);
  assign last_row = (row_b == win_cur.height - 11'd1);

  // Pixel step
  always_comb begin
    pix_nxt      = pix_r;
    chan_nxt     = chan_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    fcnt_nxt     = fcnt_r;
    complete_nxt = complete_r;
    res          = '0;
    res.status   = ST_OK;
    if (item.command) begin
      // restart: flush if any part of a pixel was taken
      res.flush    = (pix_r != '0) || (chan_r != 2'd0);
      pix_nxt      = '0;
      chan_nxt     = 2'd0;
      col_nxt      = 11'd0;
      row_nxt      = 11'd0;
      fcnt_nxt     = '0;
      complete_nxt = 1'b0;
    end else if (pixel_phase) begin
      if (!item.is_data) begin
        res.status = ST_CMD_IN_PIXELS;
      end else begin
        res.write_valid = 1'b1;
        res.pixel_index = pidx32[19:0];
        res.channel     = chan_b;
        res.pixel_value = item.data_byte;
        complete_nxt    = 1'b0;
        pix_nxt         = pix_b;
        col_nxt         = col_b;
        row_nxt         = row_b;
        fcnt_nxt        = fcnt_b;
        chan_nxt        = chan_b + 2'd1;
        if (chan_b == 2'd2) begin
          // blue closes the pixel
          chan_nxt = 2'd0;
          pix_nxt  = pix_b + PIX_W'(1);
          if (last_col) begin
            col_nxt = 11'd0;
            row_nxt = row_b + 11'd1;
          end else begin
            col_nxt = col_b + 11'd1;
          end
          fcnt_nxt       = (fcnt_b == FCNT_LAST) ? '0 : fcnt_b + FCNT_W'(1);
          res.frame_done = last_col && last_row;
          res.flush      = (last_col && last_row) || (fcnt_b == FCNT_LAST);
          complete_nxt   = last_col && last_row;
        end
      end
    end else if (win_set) begin
      pix_nxt      = '0;
      chan_nxt     = 2'd0;
      col_nxt      = 11'd0;
      row_nxt      = 11'd0;
      fcnt_nxt     = '0;
      complete_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r      <= '0;
      chan_r     <= 2'd0;
      col_r      <= 11'd0;
      row_r      <= 11'd0;
      fcnt_r     <= '0;
      complete_r <= 1'b0;
    end else if (commit) begin
      pix_r      <= pix_nxt;
      chan_r     <= chan_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      fcnt_r     <= fcnt_nxt;
      complete_r <= complete_nxt;
    end
  end

endmodule
